// ===== design/sibk_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sibk_pkg
// types shared by the insertion sort cell row and its top level
// ----------------------------------------------------------------------------
package sibk_pkg;

	localparam int ID_W  = 16;
	localparam int KEY_W = 32;

	typedef struct packed {
		logic [ID_W-1:0]  id;
		logic [KEY_W-1:0] key;
	} entry_t;

	typedef struct packed {
		logic ins;
		logic drain;
		logic prev_take;
	} cell_ctl_t;

endpackage

`default_nettype wire

// ===== design/sibk_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sibk_cell
// one slot of the sorted row: takes the new entry, its left neighbor's entry
// on insert, or its right neighbor's entry while the row drains
// ----------------------------------------------------------------------------
module sibk_cell (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire sibk_pkg::cell_ctl_t  ctl,
	input  wire sibk_pkg::entry_t     new_data,
	input  wire sibk_pkg::entry_t     left_data,
	input  wire                       left_valid,
	input  wire sibk_pkg::entry_t     right_data,
	input  wire                       right_valid,
	output sibk_pkg::entry_t          data,
	output logic                      valid,
	output logic                      take
);

	sibk_pkg::entry_t data_q;
	logic             valid_q;
	sibk_pkg::entry_t nxt_data;
	logic             nxt_valid;

	always_comb begin
		take = !valid_q || ($signed(data_q.key) > $signed(new_data.key));
	end

	always_comb begin
		nxt_data  = data_q;
		nxt_valid = valid_q;
		if (ctl.ins) begin
			if (ctl.prev_take) begin
				nxt_data  = left_data;
				nxt_valid = left_valid;
			end else if (take) begin
				nxt_data  = new_data;
				nxt_valid = 1'b1;
			end
		end else if (ctl.drain) begin
			nxt_data  = right_data;
			nxt_valid = right_valid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= nxt_valid;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= nxt_data;
	end

	assign data  = data_q;
	assign valid = valid_q;

endmodule

`default_nettype wire

// ===== design/stable_insertion_sort_by_key_core.sv =====
// input: one transaction per cycle unless stalled; each key that fits is
//   placed in the row as it is taken, by a compare in every cell at once
// output: after the transaction marked last, the held entries leave one per
//   cycle from the head cell while out_stall is low; input is stalled until
//   the final one is taken; out_valid rises in the cycle after last is taken
// reset: clears the cell valid bits, the drain flag and the overflow flag
`default_nettype none
// ----------------------------------------------------------------------------
// stable_insertion_sort_by_key_core
// stable insertion sort of a run of (id, signed key) pairs in a cell row
// ----------------------------------------------------------------------------
module stable_insertion_sort_by_key_core #(
	parameter int MAX_ENTRIES = 32
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_stall,
	input  wire  [15:0]        entity_id,
	input  wire signed [31:0]  z_order,
	input  wire                last,
	output logic               out_valid,
	input  wire                out_stall,
	output logic [15:0]        sorted_id,
	output logic signed [31:0] sorted_key,
	output logic               last_out,
	output logic               overflow
);

	sibk_pkg::entry_t          cell_data  [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0]    cell_valid;
	logic [MAX_ENTRIES-1:0]    cell_take;
	sibk_pkg::cell_ctl_t       cell_ctl   [MAX_ENTRIES];
	sibk_pkg::entry_t          new_entry;

	logic draining_q;
	logic dropped_q;
	logic in_fire;
	logic out_fire;
	logic full;
	logic ins;
	logic drain;

	assign new_entry.id  = entity_id;
	assign new_entry.key = z_order;

	assign full     = cell_valid[MAX_ENTRIES-1];
	assign in_stall = draining_q;
	assign in_fire  = in_valid && !draining_q;
	assign ins      = in_fire && !full;

	assign out_valid  = draining_q;
	assign out_fire   = draining_q && !out_stall;
	assign drain      = out_fire;
	assign sorted_id  = cell_data[0].id;
	assign sorted_key = cell_data[0].key;
	assign last_out   = !cell_valid[1];
	assign overflow   = dropped_q;

	genvar gi;
	generate
		for (gi = 0; gi < MAX_ENTRIES; gi++) begin : g_cell
			sibk_pkg::entry_t left_d;
			logic             left_v;
			sibk_pkg::entry_t right_d;
			logic             right_v;

			if (gi == 0) begin : g_head
				assign left_d = new_entry;
				assign left_v = 1'b0;
				assign cell_ctl[gi].prev_take = 1'b0;
			end else begin : g_body
				assign left_d = cell_data[gi-1];
				assign left_v = cell_valid[gi-1];
				assign cell_ctl[gi].prev_take = cell_take[gi-1];
			end

			if (gi == MAX_ENTRIES-1) begin : g_tail
				assign right_d = '0;
				assign right_v = 1'b0;
			end else begin : g_mid
				assign right_d = cell_data[gi+1];
				assign right_v = cell_valid[gi+1];
			end

			assign cell_ctl[gi].ins   = ins;
			assign cell_ctl[gi].drain = drain;

			sibk_cell u_cell (
				.clk         (clk),
				.arst_n      (arst_n),
				.ctl         (cell_ctl[gi]),
				.new_data    (new_entry),
				.left_data   (left_d),
				.left_valid  (left_v),
				.right_data  (right_d),
				.right_valid (right_v),
				.data        (cell_data[gi]),
				.valid       (cell_valid[gi]),
				.take        (cell_take[gi])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			draining_q <= 1'b0;
			dropped_q  <= 1'b0;
		end else begin
			if (in_fire) begin
				if (full) begin
					dropped_q <= 1'b1;
				end
				if (last) begin
					draining_q <= 1'b1;
				end
			end else if (out_fire && last_out) begin
				draining_q <= 1'b0;
				dropped_q  <= 1'b0;
			end
		end
	end

	// valid bits stay packed toward the head cell
	assert property (@(posedge clk) disable iff (!arst_n)
		(cell_valid & (cell_valid + MAX_ENTRIES'(1))) == '0)
		else $error("cell valid bits not contiguous");

	// a result is only offered from a held entry
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> cell_valid[0])
		else $error("result offered from empty head cell");

	// the row is empty after the final result of a run
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_fire && last_out) |=> (cell_valid == '0) && !dropped_q)
		else $error("row not cleared after final result");

	// an accepted transaction that fits adds exactly one entry
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && !full) |=> $countones(cell_valid) == $past($countones(cell_valid)) + 1)
		else $error("insert did not add one entry");

endmodule

`default_nettype wire
